@@ rtl/sample_voice_stereo_mixer_macros.svh @@
// Assertion macros for the sample voice mixer checker.
// Used by svsm_chk; no other dependencies.
`ifndef SAMPLE_VOICE_STEREO_MIXER_MACROS_SVH
`define SAMPLE_VOICE_STEREO_MIXER_MACROS_SVH

// Checked only while out of reset.
`define SVSM_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define SVSM_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/svsm_pkg.sv @@
// Shared types, codes and constants for the sample voice stereo mixer.
// No dependencies.
package svsm_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF = 16384;

  localparam int unsigned FRAC_BITS   = 14;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned START_W     = 28;
  localparam int unsigned STEP_W      = 20;
  localparam int unsigned LEN_W       = 29;
  localparam int unsigned LOAD_ADDR_W = 14;
  localparam int unsigned SMP_W       = 8;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned LVL_W       = 8;
  localparam int unsigned VS_W        = 2 * LVL_W;
  localparam int unsigned GPROD_W     = LVL_W + VS_W;
  localparam int unsigned GAIN_W      = 12;
  localparam int unsigned PROD_W      = SMP_W + GAIN_W + 1;
  localparam int unsigned SUM_W       = ACC_W + 2;

  localparam int unsigned GAIN_SHIFT_INT = 16;
  localparam int unsigned GAIN_SHIFT_LIN = 12;
  localparam int unsigned MIX_SHIFT      = 8;

  localparam logic [LVL_W-1:0] PAN_MAX = 8'hFF;

  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_AW = 5;

  localparam logic [LVL_W-1:0]  RST_VOLUME = 8'd255;
  localparam logic [LVL_W-1:0]  RST_PAN    = 8'd128;
  localparam logic [LVL_W-1:0]  RST_SCALE  = 8'd64;
  localparam logic [STEP_W-1:0] RST_STEP   = 20'd16384;
  localparam logic [LEN_W-1:0]  RST_LEN    = 29'd16384;
  localparam logic [LEN_W-1:0]  RST_LOOP   = 29'd0;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_MIX   = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_XFADE  = 3'd0,
    REG_VOLUME = 3'd1,
    REG_PAN    = 3'd2,
    REG_SCALE  = 3'd3,
    REG_STEP   = 3'd4,
    REG_LEN    = 3'd5,
    REG_LOOP   = 3'd6
  } reg_e;

  typedef struct packed {
    logic              xfade;
    logic [LVL_W-1:0]  volume;
    logic [LVL_W-1:0]  pan;
    logic [LVL_W-1:0]  scale;
    logic [STEP_W-1:0] step;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  loop;
  } cfg_t;

  // First stage word: voice flags, accumulators and gain operands.
  typedef struct packed {
    logic                    on;
    logic                    still;
    logic                    last;
    logic signed [ACC_W-1:0] acc_l;
    logic signed [ACC_W-1:0] acc_r;
    logic                    xfade;
    logic [LVL_W-1:0]        mr;
    logic [LVL_W-1:0]        ml;
    logic [VS_W-1:0]         vs;
  } s1_t;

endpackage

@@ rtl/svsm_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on svsm_pkg.
module svsm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svsm_pkg::CFG_AW-1:0]  paddr,
  input  logic [svsm_pkg::CFG_DW-1:0]  pwdata,
  output logic [svsm_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output svsm_pkg::cfg_t               cfg_o
);

  svsm_pkg::cfg_t cfg_q;
  logic           wr;
  logic [2:0]     idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xfade  <= 1'b0;
      cfg_q.volume <= svsm_pkg::RST_VOLUME;
      cfg_q.pan    <= svsm_pkg::RST_PAN;
      cfg_q.scale  <= svsm_pkg::RST_SCALE;
      cfg_q.step   <= svsm_pkg::RST_STEP;
      cfg_q.len    <= svsm_pkg::RST_LEN;
      cfg_q.loop   <= svsm_pkg::RST_LOOP;
    end else if (wr) begin
      unique case (svsm_pkg::reg_e'(idx))
        svsm_pkg::REG_XFADE:  cfg_q.xfade  <= pwdata[0];
        svsm_pkg::REG_VOLUME: cfg_q.volume <= pwdata[svsm_pkg::LVL_W-1:0];
        svsm_pkg::REG_PAN:    cfg_q.pan    <= pwdata[svsm_pkg::LVL_W-1:0];
        svsm_pkg::REG_SCALE:  cfg_q.scale  <= pwdata[svsm_pkg::LVL_W-1:0];
        svsm_pkg::REG_STEP:   cfg_q.step   <= pwdata[svsm_pkg::STEP_W-1:0];
        svsm_pkg::REG_LEN:    cfg_q.len    <= pwdata[svsm_pkg::LEN_W-1:0];
        svsm_pkg::REG_LOOP:   cfg_q.loop   <= pwdata[svsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (svsm_pkg::reg_e'(idx))
      svsm_pkg::REG_XFADE:  prdata = svsm_pkg::CFG_DW'(cfg_q.xfade);
      svsm_pkg::REG_VOLUME: prdata = svsm_pkg::CFG_DW'(cfg_q.volume);
      svsm_pkg::REG_PAN:    prdata = svsm_pkg::CFG_DW'(cfg_q.pan);
      svsm_pkg::REG_SCALE:  prdata = svsm_pkg::CFG_DW'(cfg_q.scale);
      svsm_pkg::REG_STEP:   prdata = svsm_pkg::CFG_DW'(cfg_q.step);
      svsm_pkg::REG_LEN:    prdata = svsm_pkg::CFG_DW'(cfg_q.len);
      svsm_pkg::REG_LOOP:   prdata = svsm_pkg::CFG_DW'(cfg_q.loop);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/svsm_voice.sv @@
// Voice state, sample store and first stage: position update, store read, gain operands.
// Depends on svsm_pkg.
module svsm_voice #(
  parameter int unsigned SAMPLE_DEPTH = svsm_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                acc_i,
  input  logic                                take_i,
  input  logic [1:0]                          kind_i,
  input  logic [svsm_pkg::LOAD_ADDR_W-1:0]    load_address_i,
  input  logic signed [svsm_pkg::SMP_W-1:0]   load_value_i,
  input  logic [svsm_pkg::START_W-1:0]        start_position_i,
  input  logic signed [svsm_pkg::ACC_W-1:0]   accum_left_in_i,
  input  logic signed [svsm_pkg::ACC_W-1:0]   accum_right_in_i,
  input  logic                                frame_last_i,
  input  svsm_pkg::cfg_t                      cfg_i,
  output logic                                s1_valid_o,
  output svsm_pkg::s1_t                       s1_o,
  output logic signed [svsm_pkg::SMP_W-1:0]   smp_o
);

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  logic signed [svsm_pkg::SMP_W-1:0] mem [SAMPLE_DEPTH];

  logic [svsm_pkg::POS_W-1:0] pos_q, pos_d, pos_sum;
  logic                       on_q, on_d;
  logic                       s1_valid_q;
  svsm_pkg::s1_t              s1_q;
  logic signed [svsm_pkg::SMP_W-1:0] smp_q;

  logic is_load, is_mix, is_start;
  logic wr_ok, mix_on, wrap;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   idx_full, cnt;
  logic [svsm_pkg::LVL_W-1:0] q_pan;
  logic [svsm_pkg::VS_W-1:0]  pp, qq, vs;

  always_comb begin
    is_load  = 1'b0;
    is_mix   = 1'b0;
    is_start = 1'b0;
    unique case (svsm_pkg::kind_e'(kind_i))
      svsm_pkg::KIND_LOAD:  is_load  = 1'b1;
      svsm_pkg::KIND_MIX:   is_mix   = 1'b1;
      svsm_pkg::KIND_START: is_start = 1'b1;
      default: ;
    endcase
  end

  assign wr_ok   = 32'(load_address_i) < 32'(SAMPLE_DEPTH);
  assign wr_addr = AW'(load_address_i);

  // read index: integer part, clamped to last sample and to store depth
  always_comb begin
    idx_full = 32'(pos_q >> svsm_pkg::FRAC_BITS);
    cnt      = 32'(cfg_i.len >> svsm_pkg::FRAC_BITS);
    if (cnt == 32'd0) begin
      idx_full = 32'd0;
    end else if (idx_full >= cnt) begin
      idx_full = cnt - 32'd1;
    end
    if (idx_full >= 32'(SAMPLE_DEPTH)) begin
      idx_full = 32'(SAMPLE_DEPTH - 1);
    end
    rd_addr = idx_full[AW-1:0];
  end

  assign pos_sum = pos_q + svsm_pkg::POS_W'(cfg_i.step);
  assign wrap    = pos_sum >= svsm_pkg::POS_W'(cfg_i.len);
  assign mix_on  = acc_i && is_mix && on_q;

  always_comb begin
    pos_d = pos_q;
    on_d  = on_q;
    if (acc_i && is_start) begin
      pos_d = svsm_pkg::POS_W'(start_position_i);
      on_d  = 1'b1;
    end else if (mix_on) begin
      pos_d = pos_sum;
      if (wrap) begin
        if (cfg_i.loop != '0) begin
          pos_d = pos_sum - svsm_pkg::POS_W'(cfg_i.loop);
        end else begin
          on_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      on_q       <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      on_q  <= on_d;
      if (take_i) begin
        s1_valid_q <= acc_i && is_mix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && is_load && wr_ok) begin
      mem[wr_addr] <= load_value_i;
    end
    if (take_i) begin
      smp_q <= mem[rd_addr];
    end
  end

  assign q_pan = svsm_pkg::PAN_MAX - cfg_i.pan;
  assign pp    = svsm_pkg::VS_W'(cfg_i.pan) * svsm_pkg::VS_W'(cfg_i.pan);
  assign qq    = svsm_pkg::VS_W'(q_pan) * svsm_pkg::VS_W'(q_pan);
  assign vs    = svsm_pkg::VS_W'(cfg_i.volume) * svsm_pkg::VS_W'(cfg_i.scale);

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_q.on    <= on_q;
      s1_q.still <= on_d;
      s1_q.last  <= frame_last_i;
      s1_q.acc_l <= accum_left_in_i;
      s1_q.acc_r <= accum_right_in_i;
      s1_q.xfade <= cfg_i.xfade;
      s1_q.mr    <= cfg_i.xfade ? cfg_i.pan : pp[svsm_pkg::VS_W-1:svsm_pkg::LVL_W];
      s1_q.ml    <= cfg_i.xfade ? q_pan : qq[svsm_pkg::VS_W-1:svsm_pkg::LVL_W];
      s1_q.vs    <= vs;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign smp_o      = smp_q;

endmodule

@@ rtl/svsm_mix.sv @@
// Gain, product and saturating add stages with the output register.
// Depends on svsm_pkg.
module svsm_mix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s1_valid_i,
  input  svsm_pkg::s1_t                      s1_i,
  input  logic signed [svsm_pkg::SMP_W-1:0]  smp_i,
  output logic                               take1_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [svsm_pkg::ACC_W-1:0]  accum_left_out_o,
  output logic signed [svsm_pkg::ACC_W-1:0]  accum_right_out_o,
  output logic                               still_active_o,
  output logic                               frame_last_out_o
);

  localparam int unsigned ACC_W  = svsm_pkg::ACC_W;
  localparam int unsigned SUM_W  = svsm_pkg::SUM_W;
  localparam int unsigned PROD_W = svsm_pkg::PROD_W;
  localparam int unsigned GAIN_W = svsm_pkg::GAIN_W;

  logic v2_q, v3_q, vo_q;
  logic take2, take3, take_o;

  logic signed [svsm_pkg::SMP_W-1:0] smp2_q;
  logic [GAIN_W-1:0]                 gl_q, gr_q, gl_d, gr_d;
  logic signed [ACC_W-1:0]           acc_l2_q, acc_r2_q, acc_l3_q, acc_r3_q;
  logic                              still2_q, last2_q, still3_q, last3_q;
  logic [svsm_pkg::GPROD_W-1:0]      gpl, gpr;

  logic signed [PROD_W-1:0] sx, glx, grx, pl_q, pr_q, pl_sh, pr_sh;
  logic signed [SUM_W-1:0]  sum_l, sum_r;
  logic signed [ACC_W-1:0]  sat_l, sat_r;
  logic signed [ACC_W-1:0]  out_l_q, out_r_q;
  logic                     out_still_q, out_last_q;

  assign take_o  = !vo_q || !out_stall_i;
  assign take3   = !v3_q || take_o;
  assign take2   = !v2_q || take3;
  assign take1_o = !s1_valid_i || take2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (take2) v2_q <= s1_valid_i;
      if (take3) v3_q <= v2_q;
      if (take_o) vo_q <= v3_q;
    end
  end

  // gains
  assign gpl = svsm_pkg::GPROD_W'(s1_i.ml) * svsm_pkg::GPROD_W'(s1_i.vs);
  assign gpr = svsm_pkg::GPROD_W'(s1_i.mr) * svsm_pkg::GPROD_W'(s1_i.vs);

  always_comb begin
    if (s1_i.xfade) begin
      gl_d = GAIN_W'(gpl >> svsm_pkg::GAIN_SHIFT_LIN);
      gr_d = GAIN_W'(gpr >> svsm_pkg::GAIN_SHIFT_LIN);
    end else begin
      gl_d = GAIN_W'(gpl >> svsm_pkg::GAIN_SHIFT_INT);
      gr_d = GAIN_W'(gpr >> svsm_pkg::GAIN_SHIFT_INT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take2) begin
      smp2_q   <= s1_i.on ? smp_i : '0;
      gl_q     <= gl_d;
      gr_q     <= gr_d;
      acc_l2_q <= s1_i.acc_l;
      acc_r2_q <= s1_i.acc_r;
      still2_q <= s1_i.still;
      last2_q  <= s1_i.last;
    end
  end

  // products
  assign sx  = PROD_W'(smp2_q);
  assign glx = PROD_W'({1'b0, gl_q});
  assign grx = PROD_W'({1'b0, gr_q});

  always_ff @(posedge clk_i) begin
    if (take3) begin
      pl_q     <= sx * glx;
      pr_q     <= sx * grx;
      acc_l3_q <= acc_l2_q;
      acc_r3_q <= acc_r2_q;
      still3_q <= still2_q;
      last3_q  <= last2_q;
    end
  end

  // floor shift, add, saturate
  assign pl_sh = pl_q >>> svsm_pkg::MIX_SHIFT;
  assign pr_sh = pr_q >>> svsm_pkg::MIX_SHIFT;
  assign sum_l = SUM_W'(acc_l3_q) + SUM_W'(pl_sh);
  assign sum_r = SUM_W'(acc_r3_q) + SUM_W'(pr_sh);

  always_comb begin
    if (sum_l[SUM_W-1:ACC_W-1] == '0 || sum_l[SUM_W-1:ACC_W-1] == '1) begin
      sat_l = sum_l[ACC_W-1:0];
    end else begin
      sat_l = {sum_l[SUM_W-1], {(ACC_W-1){!sum_l[SUM_W-1]}}};
    end
    if (sum_r[SUM_W-1:ACC_W-1] == '0 || sum_r[SUM_W-1:ACC_W-1] == '1) begin
      sat_r = sum_r[ACC_W-1:0];
    end else begin
      sat_r = {sum_r[SUM_W-1], {(ACC_W-1){!sum_r[SUM_W-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_l_q     <= sat_l;
      out_r_q     <= sat_r;
      out_still_q <= still3_q;
      out_last_q  <= last3_q;
    end
  end

  assign out_valid_o       = vo_q;
  assign accum_left_out_o  = out_l_q;
  assign accum_right_out_o = out_r_q;
  assign still_active_o    = out_still_q;
  assign frame_last_out_o  = out_last_q;

endmodule

@@ rtl/sample_voice_stereo_mixer.sv @@
// Top level of the sample voice stereo mixer: register file, voice stage, mix stages.
// Depends on svsm_pkg, svsm_regs, svsm_voice, svsm_mix.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o | kind, load, start, accumulators, last
//   out     | output    | out_valid_o/out_stall_i | mixed accumulators, active, last
//   cfg     | input     | psel/penable/pwrite     | 7 registers at 4*i, pready tied high
//
// One word is taken per cycle while the input is not stalled. A mix word passes the
// first-stage, gain, product and output registers; load, start and unknown words give
// none. The rate is set by the position add/compare/subtract and the one store read port
// in the first stage. Reset clears voice state, registers and stage valids; the sample store
// is not cleared. The input stalls only when every stage is full and the output is stalled.
module sample_voice_stereo_mixer #(
  parameter int unsigned SAMPLE_DEPTH = svsm_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [svsm_pkg::CFG_AW-1:0]         paddr,
  input  logic [svsm_pkg::CFG_DW-1:0]         pwdata,
  output logic [svsm_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          kind_i,
  input  logic [svsm_pkg::LOAD_ADDR_W-1:0]    load_address_i,
  input  logic signed [svsm_pkg::SMP_W-1:0]   load_value_i,
  input  logic [svsm_pkg::START_W-1:0]        start_position_i,
  input  logic signed [svsm_pkg::ACC_W-1:0]   accum_left_in_i,
  input  logic signed [svsm_pkg::ACC_W-1:0]   accum_right_in_i,
  input  logic                                frame_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [svsm_pkg::ACC_W-1:0]   accum_left_out_o,
  output logic signed [svsm_pkg::ACC_W-1:0]   accum_right_out_o,
  output logic                                still_active_o,
  output logic                                frame_last_out_o
);

  svsm_pkg::cfg_t cfg;
  svsm_pkg::s1_t  s1;
  logic           s1_valid;
  logic           take1;
  logic           in_acc;
  logic signed [svsm_pkg::SMP_W-1:0] smp;

  assign in_stall_o = !take1;
  assign in_acc     = in_valid_i && take1;

  svsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  svsm_voice #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_voice (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (in_acc),
    .take_i           (take1),
    .kind_i           (kind_i),
    .load_address_i   (load_address_i),
    .load_value_i     (load_value_i),
    .start_position_i (start_position_i),
    .accum_left_in_i  (accum_left_in_i),
    .accum_right_in_i (accum_right_in_i),
    .frame_last_i     (frame_last_i),
    .cfg_i            (cfg),
    .s1_valid_o       (s1_valid),
    .s1_o             (s1),
    .smp_o            (smp)
  );

  svsm_mix u_mix (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s1_valid_i        (s1_valid),
    .s1_i              (s1),
    .smp_i             (smp),
    .take1_o           (take1),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accum_left_out_o  (accum_left_out_o),
    .accum_right_out_o (accum_right_out_o),
    .still_active_o    (still_active_o),
    .frame_last_out_o  (frame_last_out_o)
  );

endmodule

@@ rtl/svsm_chk.sv @@
// Port-level checker for the sample voice stereo mixer, bound to the top level.
// Depends on sample_voice_stereo_mixer_macros.svh and svsm_pkg.
`include "sample_voice_stereo_mixer_macros.svh"

module svsm_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [svsm_pkg::ACC_W-1:0]  accum_left_out_o,
  input logic signed [svsm_pkg::ACC_W-1:0]  accum_right_out_o,
  input logic                               still_active_o,
  input logic                               frame_last_out_o
);

  // held word keeps its payload
  `SVSM_ASSERT_RUN(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(accum_left_out_o) &&
    $stable(accum_right_out_o) && $stable(still_active_o) && $stable(frame_last_out_o),
    "stalled output word changed")

  // backpressure only comes from a stalled output
  `SVSM_ASSERT_RUN(a_stall_src, clk_i, rst_ni,
    in_stall_o |-> out_valid_o && out_stall_i,
    "input stalled without a stalled output")

  // reset empties the pipeline
  `SVSM_ASSERT_ALL(a_reset_empty, clk_i,
    !rst_ni |=> !out_valid_o && !in_stall_o,
    "pipeline not empty in reset")

  // an input stall does not persist once the output stall is released, unless the output holds a word
  `SVSM_ASSERT_RUN(a_no_dead_stall, clk_i, rst_ni,
    in_valid_i && in_stall_o && !out_stall_i |=> !in_stall_o || out_valid_o,
    "input stall outlived output stall")

endmodule

bind sample_voice_stereo_mixer svsm_chk u_svsm_chk (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sample_voice_stereo_mixer: directed and random words are checked
// against an in-bench model of the voice. Depends on svsm_pkg and the block's RTL.
module tb;

  localparam int unsigned DEPTH          = svsm_pkg::SAMPLE_DEPTH_DEF;
  localparam int unsigned FRAC_BITS      = svsm_pkg::FRAC_BITS;
  localparam int unsigned ACC_W          = svsm_pkg::ACC_W;
  localparam int unsigned CFG_AW         = svsm_pkg::CFG_AW;
  localparam int unsigned CFG_DW         = svsm_pkg::CFG_DW;
  localparam int unsigned LOAD_ADDR_W    = svsm_pkg::LOAD_ADDR_W;
  localparam int unsigned SMP_W          = svsm_pkg::SMP_W;
  localparam int unsigned START_W        = svsm_pkg::START_W;
  localparam int unsigned POS_W          = svsm_pkg::POS_W;
  localparam int unsigned LVL_W          = svsm_pkg::LVL_W;
  localparam int unsigned STEP_W         = svsm_pkg::STEP_W;
  localparam int unsigned LEN_W          = svsm_pkg::LEN_W;
  localparam int unsigned GAIN_SHIFT_INT = svsm_pkg::GAIN_SHIFT_INT;
  localparam int unsigned GAIN_SHIFT_LIN = svsm_pkg::GAIN_SHIFT_LIN;
  localparam int unsigned MIX_SHIFT      = svsm_pkg::MIX_SHIFT;
  localparam logic [LVL_W-1:0] PAN_MAX   = svsm_pkg::PAN_MAX;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned ONE_SMP = 1 << FRAC_BITS;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic signed [ACC_W-1:0] left;
    logic signed [ACC_W-1:0] right;
    logic                    active;
    logic                    last;
  } mix_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [CFG_DW-1:0]        pwdata = '0;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               kind_i = '0;
  logic [LOAD_ADDR_W-1:0]   load_address_i = '0;
  logic signed [SMP_W-1:0]  load_value_i = '0;
  logic [START_W-1:0]       start_position_i = '0;
  logic signed [ACC_W-1:0]  accum_left_in_i = '0;
  logic signed [ACC_W-1:0]  accum_right_in_i = '0;
  logic                     frame_last_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ACC_W-1:0]  accum_left_out_o;
  logic signed [ACC_W-1:0]  accum_right_out_o;
  logic                     still_active_o;
  logic                     frame_last_out_o;

  // voice model state
  svsm_pkg::cfg_t           cfg;
  logic signed [SMP_W-1:0]  sample_mem [DEPTH];
  bit                       loaded [DEPTH];
  logic [POS_W-1:0]         play_pos = '0;
  bit                       voice_on = 1'b0;
  mix_result_t              pending_mixes [$];
  int                       mismatches = 0;

  bit                       src_gaps_on = 1'b1;
  bit                       sink_gaps_on = 1'b1;
  int unsigned              hold_req = 0;
  int unsigned              stall_run = 0;

  sample_voice_stereo_mixer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .load_address_i    (load_address_i),
    .load_value_i      (load_value_i),
    .start_position_i  (start_position_i),
    .accum_left_in_i   (accum_left_in_i),
    .accum_right_in_i  (accum_right_in_i),
    .frame_last_i      (frame_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accum_left_out_o  (accum_left_out_o),
    .accum_right_out_o (accum_right_out_o),
    .still_active_o    (still_active_o),
    .frame_last_out_o  (frame_last_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver stall: random runs, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      out_stall_i = 1'b1;
      hold_req--;
    end else if (stall_run > 0) begin
      out_stall_i = 1'b1;
      stall_run--;
    end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_result
    mix_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_mixes.size() == 0) begin
        $display("%0t: unexpected word: left %0d right %0d active %0b last %0b", $time,
                 accum_left_out_o, accum_right_out_o, still_active_o, frame_last_out_o);
        mismatches++;
      end else begin
        want = pending_mixes.pop_front();
        if (accum_left_out_o !== want.left) begin
          $display("%0t: left expected %0d got %0d", $time, want.left, accum_left_out_o);
          mismatches++;
        end
        if (accum_right_out_o !== want.right) begin
          $display("%0t: right expected %0d got %0d", $time, want.right, accum_right_out_o);
          mismatches++;
        end
        if (still_active_o !== want.active) begin
          $display("%0t: active expected %0b got %0b", $time, want.active, still_active_o);
          mismatches++;
        end
        if (frame_last_out_o !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, frame_last_out_o);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [ACC_W-1:0] clip16(int x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[ACC_W-1:0];
  endfunction

  function automatic int unsigned read_index();
    int unsigned idx;
    int unsigned cnt;
    idx = play_pos >> FRAC_BITS;
    cnt = 32'(cfg.len) >> FRAC_BITS;
    if (cnt == 0) idx = 0;
    else if (idx >= cnt) idx = cnt - 1;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return idx;
  endfunction

  function automatic mix_result_t mix_frame(logic signed [ACC_W-1:0] al,
                                            logic signed [ACC_W-1:0] ar, logic lst);
    mix_result_t res;
    int unsigned p;
    int unsigned q;
    int unsigned vs;
    int gl;
    int gr;
    int smp;
    int sl;
    int sr;
    sl = al;
    sr = ar;
    if (voice_on) begin
      p = cfg.pan;
      q = 32'(PAN_MAX) - p;
      vs = 32'(cfg.volume) * 32'(cfg.scale);
      if (!cfg.xfade) begin
        gr = (((p * p) >> 8) * vs) >> GAIN_SHIFT_INT;
        gl = (((q * q) >> 8) * vs) >> GAIN_SHIFT_INT;
      end else begin
        gr = (p * vs) >> GAIN_SHIFT_LIN;
        gl = (q * vs) >> GAIN_SHIFT_LIN;
      end
      smp = sample_mem[read_index()];
      sl = sl + ((smp * gl) >>> MIX_SHIFT);
      sr = sr + ((smp * gr) >>> MIX_SHIFT);
      play_pos = play_pos + cfg.step;
      if (play_pos >= cfg.len) begin
        if (cfg.loop != 0) play_pos = play_pos - cfg.loop;
        else voice_on = 1'b0;
      end
    end
    res.left = clip16(sl);
    res.right = clip16(sr);
    res.active = voice_on;
    res.last = lst;
    return res;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_word(logic [1:0] k, logic [LOAD_ADDR_W-1:0] addr,
                           logic signed [SMP_W-1:0] val, logic [START_W-1:0] start,
                           logic signed [ACC_W-1:0] al, logic signed [ACC_W-1:0] ar,
                           logic lst);
    int unsigned gap;
    in_valid_i = 1'b1;
    kind_i = k;
    load_address_i = addr;
    load_value_i = val;
    start_position_i = start;
    accum_left_in_i = al;
    accum_right_in_i = ar;
    frame_last_i = lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (k)
      svsm_pkg::KIND_LOAD: begin
        sample_mem[addr] = val;
        loaded[addr] = 1'b1;
      end
      svsm_pkg::KIND_START: begin
        play_pos = 32'(start);
        voice_on = 1'b1;
      end
      svsm_pkg::KIND_MIX: pending_mixes.push_back(mix_frame(al, ar, lst));
      default: ;
    endcase
    gap = 0;
    if (src_gaps_on) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(5, 30);
      endcase
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic load_word(logic [LOAD_ADDR_W-1:0] addr, logic signed [SMP_W-1:0] val);
    send_word(svsm_pkg::KIND_LOAD, addr, val, START_W'($urandom), ACC_W'($urandom),
              ACC_W'($urandom), 1'($urandom));
  endtask

  task automatic start_word(logic [START_W-1:0] start);
    send_word(svsm_pkg::KIND_START, LOAD_ADDR_W'($urandom), SMP_W'($urandom), start,
              ACC_W'($urandom), ACC_W'($urandom), 1'($urandom));
  endtask

  task automatic odd_word();
    send_word(KIND_NONE, LOAD_ADDR_W'($urandom), SMP_W'($urandom), START_W'($urandom),
              ACC_W'($urandom), ACC_W'($urandom), 1'($urandom));
  endtask

  // the sample about to be read is always written first
  task automatic mix_word(logic signed [ACC_W-1:0] al, logic signed [ACC_W-1:0] ar,
                          logic lst);
    int unsigned idx;
    idx = read_index();
    if (voice_on && !loaded[idx]) load_word(LOAD_ADDR_W'(idx), SMP_W'($urandom));
    send_word(svsm_pkg::KIND_MIX, LOAD_ADDR_W'($urandom), SMP_W'($urandom),
              START_W'($urandom), al, ar, lst);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_mixes.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(svsm_pkg::reg_e r, logic [CFG_DW-1:0] v);
    wait_idle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (r)
      svsm_pkg::REG_XFADE:  cfg.xfade = v[0];
      svsm_pkg::REG_VOLUME: cfg.volume = v[LVL_W-1:0];
      svsm_pkg::REG_PAN:    cfg.pan = v[LVL_W-1:0];
      svsm_pkg::REG_SCALE:  cfg.scale = v[LVL_W-1:0];
      svsm_pkg::REG_STEP:   cfg.step = v[STEP_W-1:0];
      svsm_pkg::REG_LEN:    cfg.len = v[LEN_W-1:0];
      svsm_pkg::REG_LOOP:   cfg.loop = v[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic signed [ACC_W-1:0] pick_accum();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return ACC_W'($urandom_range(0, 200)) - 16'sd100 + 16'sh8000;
      default: return ACC_W'($urandom);
    endcase
  endfunction

  // mode 0: all minimums, mode 1: all maximums, else random
  task automatic random_setup(int mode);
    logic [CFG_DW-1:0] len;
    logic [CFG_DW-1:0] step;
    logic [CFG_DW-1:0] loop;
    if (mode == 0) begin
      write_reg(svsm_pkg::REG_XFADE, 0);
      write_reg(svsm_pkg::REG_VOLUME, 0);
      write_reg(svsm_pkg::REG_PAN, 0);
      write_reg(svsm_pkg::REG_SCALE, 0);
      write_reg(svsm_pkg::REG_STEP, 0);
      write_reg(svsm_pkg::REG_LEN, ONE_SMP);
      write_reg(svsm_pkg::REG_LOOP, 0);
    end else if (mode == 1) begin
      write_reg(svsm_pkg::REG_XFADE, 1);
      write_reg(svsm_pkg::REG_VOLUME, 255);
      write_reg(svsm_pkg::REG_PAN, 255);
      write_reg(svsm_pkg::REG_SCALE, 255);
      write_reg(svsm_pkg::REG_STEP, 32'hFFFFF);
      write_reg(svsm_pkg::REG_LEN, 32'h1000_0000);
      write_reg(svsm_pkg::REG_LOOP, 32'h1000_0000);
    end else begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(ONE_SMP, 32'h1000_0000)
                                        : $urandom_range(ONE_SMP, 40 * ONE_SMP);
      case ($urandom_range(0, 9))
        0: step = $urandom_range(0, 32'hFFFFF);
        1: step = 0;
        default: step = $urandom_range(1, 3 * ONE_SMP);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: loop = 0;
        3: loop = $urandom_range(0, 32'h1000_0000);
        default: loop = $urandom_range(1, len);
      endcase
      write_reg(svsm_pkg::REG_XFADE, $urandom_range(0, 1));
      write_reg(svsm_pkg::REG_VOLUME,
                ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255));
      write_reg(svsm_pkg::REG_PAN, $urandom_range(0, 255));
      write_reg(svsm_pkg::REG_SCALE,
                ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255));
      write_reg(svsm_pkg::REG_STEP, step);
      write_reg(svsm_pkg::REG_LEN, len);
      write_reg(svsm_pkg::REG_LOOP, loop);
    end
  endtask

  task automatic test_inactive_voice();
    mix_word(16'sh8000, 16'sh7FFF, 1'b1);
    mix_word(16'sh7FFF, 16'sh8000, 1'b0);
    odd_word();
    wait_idle();
  endtask

  task automatic test_gain_extremes();
    write_reg(svsm_pkg::REG_XFADE, 1);
    write_reg(svsm_pkg::REG_VOLUME, 255);
    write_reg(svsm_pkg::REG_SCALE, 255);
    write_reg(svsm_pkg::REG_PAN, 0);
    write_reg(svsm_pkg::REG_STEP, ONE_SMP);
    write_reg(svsm_pkg::REG_LEN, 2 * ONE_SMP);
    write_reg(svsm_pkg::REG_LOOP, 0);
    load_word(0, -8'sd128);
    load_word(1, 8'sd127);
    start_word(0);
    mix_word(16'sh8000, 16'sh7FFF, 1'b1);
    mix_word(16'sh7FFF, 16'sh8000, 1'b0);
    mix_word(16'sd100, -16'sd100, 1'b1);
    write_reg(svsm_pkg::REG_PAN, 255);
    write_reg(svsm_pkg::REG_XFADE, 0);
    start_word(ONE_SMP);
    mix_word(16'sh8000, 16'sh7FFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_end_and_restart();
    write_reg(svsm_pkg::REG_LEN, 32'h1000_0000);
    write_reg(svsm_pkg::REG_LOOP, ONE_SMP);
    write_reg(svsm_pkg::REG_STEP, 32'hFFFFF);
    load_word(LOAD_ADDR_W'(DEPTH - 1), 8'sd127);
    start_word(28'hFFF_FFFF);
    mix_word(16'sd0, 16'sd0, 1'b0);
    odd_word();
    mix_word(16'sd1, -16'sd1, 1'b1);
    start_word(0);
    mix_word(-16'sd1, 16'sd1, 1'b0);
    mix_word(16'sh8000, 16'sh8000, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    start_word(0);
    src_gaps_on = 1'b0;
    hold_req = 200;
    repeat (80) mix_word(pick_accum(), pick_accum(), 1'($urandom));
    src_gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_mix();
    int unsigned r;
    for (int ph = 0; ph < 12; ph++) begin
      src_gaps_on = (ph % 4 != 2);
      sink_gaps_on = (ph % 4 != 3);
      random_setup(ph);
      start_word(($urandom_range(0, 4) == 0) ? START_W'($urandom)
                                              : START_W'($urandom_range(0, cfg.len)));
      repeat (130) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          mix_word(pick_accum(), pick_accum(), 1'($urandom));
        end else if (r < 85) begin
          load_word(LOAD_ADDR_W'($urandom), SMP_W'($urandom));
        end else if (r < 95) begin
          start_word(($urandom_range(0, 4) == 0) ? START_W'($urandom)
                                                  : START_W'($urandom_range(0, cfg.len)));
        end else begin
          odd_word();
        end
      end
    end
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    cfg.xfade = 1'b0;
    cfg.volume = svsm_pkg::RST_VOLUME;
    cfg.pan = svsm_pkg::RST_PAN;
    cfg.scale = svsm_pkg::RST_SCALE;
    cfg.step = svsm_pkg::RST_STEP;
    cfg.len = svsm_pkg::RST_LEN;
    cfg.loop = svsm_pkg::RST_LOOP;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_inactive_voice();
    test_gain_extremes();
    test_end_and_restart();
    test_backpressure();
    test_random_mix();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
